>>> rtl/core/tpq_pkg.sv
// Shared types and constants for the touch playback queue.
// No dependencies; imported by tpq_core and touch_playback_queue_top.
`timescale 1ns / 1ps
`default_nettype none

package tpq_pkg;

    localparam int RING_SLOTS_DEF = 16;
    localparam int COORD_W        = 16;
    localparam int HOLD_W         = 16;
    localparam int TICK_W         = 32;
    localparam int ENTRY_W        = 2 * COORD_W + HOLD_W;

    typedef enum logic {
        KIND_INJECT = 1'b0,
        KIND_POLL   = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind                     kind;
        logic signed [COORD_W-1:0] touch_x;
        logic signed [COORD_W-1:0] touch_y;
        logic [HOLD_W-1:0]         hold_ms;
        logic [TICK_W-1:0]         now_ms;
    } t_item;

    typedef struct packed {
        logic                      accepted;
        logic                      pressed;
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic                      wake;
    } t_result;

endpackage

`default_nettype wire

>>> rtl/core/touch_playback_queue_top.sv
// Touch playback queue top level: input register, core and result register.
// Depends on tpq_pkg and tpq_core.
//
// Accepts one item per clock when the output side is ready and returns one
// result per item, through the input and result registers. An item is held in the
// input register, decided combinationally by the core against the queue state,
// and its result lands in the result register; while a result waits, the
// input register takes one more item and then the input side stalls.
// Injected touches are kept in a ring of RING_SLOTS entries in one RAM, of
// which RING_SLOTS-1 are usable. The head entry is prefetched from the RAM's
// registered read port each cycle, so a poll never waits on the ring.
`timescale 1ns / 1ps
`default_nettype none

module touch_playback_queue_top #(
    parameter int RING_SLOTS = tpq_pkg::RING_SLOTS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic        i_kind,
    input  wire logic signed [15:0] i_touch_x,
    input  wire logic signed [15:0] i_touch_y,
    input  wire logic [15:0] i_hold_ms,
    input  wire logic [31:0] i_now_ms,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic             o_accepted,
    output logic             o_pressed,
    output logic signed [15:0] o_point_x,
    output logic signed [15:0] o_point_y,
    output logic             o_wake
);

    import tpq_pkg::*;

    logic    r_in_valid;
    t_item   r_in;
    logic    r_out_valid;
    t_result r_out;
    t_result res;
    logic    move;

    assign move       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || move;

    tpq_core #(
        .RING_SLOTS (RING_SLOTS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (move),
        .i_item  (r_in),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (move) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in.kind    <= t_kind'(i_kind);
            r_in.touch_x <= i_touch_x;
            r_in.touch_y <= i_touch_y;
            r_in.hold_ms <= i_hold_ms;
            r_in.now_ms  <= i_now_ms;
        end
        if (move) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_accepted  = r_out.accepted;
    assign o_pressed   = r_out.pressed;
    assign o_point_x   = r_out.point_x;
    assign o_point_y   = r_out.point_y;
    assign o_wake      = r_out.wake;

endmodule

`default_nettype wire

>>> rtl/core/tpq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Read returns the old contents on a same-address write. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module tpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> rtl/core/tpq_core.sv
// Queue state, touch ring and per-item decision logic of the playback queue.
// Depends on tpq_pkg and tpq_ram.
`timescale 1ns / 1ps
`default_nettype none

module tpq_core #(
    parameter int RING_SLOTS = tpq_pkg::RING_SLOTS_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_fire,
    input  wire tpq_pkg::t_item   i_item,
    output tpq_pkg::t_result      o_res
);

    import tpq_pkg::*;

    localparam int               IDX_W = $clog2(RING_SLOTS);
    localparam logic [IDX_W-1:0] LAST  = IDX_W'(RING_SLOTS - 1);

    function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] idx);
        return (idx == LAST) ? '0 : idx + 1'b1;
    endfunction

    logic [IDX_W-1:0]         r_rd_idx, n_rd_idx;
    logic [IDX_W-1:0]         r_wr_idx, n_wr_idx;
    logic                     r_pressing, n_pressing;
    logic                     r_release, n_release;
    logic [TICK_W-1:0]        r_press_start, n_press_start;
    logic signed [COORD_W-1:0] r_last_x, n_last_x;
    logic signed [COORD_W-1:0] r_last_y, n_last_y;
    logic                     r_wake, n_wake;
    logic                     r_byp;
    logic [ENTRY_W-1:0]       r_byp_data;

    logic                     we;
    logic [ENTRY_W-1:0]       wdata;
    logic [ENTRY_W-1:0]       ram_rdata;
    logic [ENTRY_W-1:0]       head;
    logic [HOLD_W-1:0]        head_hold;
    logic [TICK_W-1:0]        elapsed;
    logic [IDX_W-1:0]         wr_next;

    assign wdata     = {i_item.touch_x, i_item.touch_y, i_item.hold_ms};
    assign head      = r_byp ? r_byp_data : ram_rdata;
    assign head_hold = head[HOLD_W-1:0];
    assign elapsed   = i_item.now_ms - r_press_start;
    assign wr_next   = ring_next(r_wr_idx);

    tpq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (RING_SLOTS)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_wr_idx),
        .i_wdata (wdata),
        .i_raddr (n_rd_idx),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_rd_idx      = r_rd_idx;
        n_wr_idx      = r_wr_idx;
        n_pressing    = r_pressing;
        n_release     = r_release;
        n_press_start = r_press_start;
        n_last_x      = r_last_x;
        n_last_y      = r_last_y;
        n_wake        = r_wake;
        we            = 1'b0;
        o_res.accepted = 1'b0;
        o_res.pressed  = 1'b0;
        o_res.wake     = 1'b0;
        if (i_fire) begin
            case (i_item.kind)
                KIND_INJECT: begin
                    if (wr_next != r_rd_idx) begin
                        we             = 1'b1;
                        n_wr_idx       = wr_next;
                        n_wake         = 1'b1;
                        o_res.accepted = 1'b1;
                    end
                end
                KIND_POLL: begin
                    o_res.wake = r_wake;
                    n_wake     = 1'b0;
                    if (r_pressing) begin
                        if (elapsed >= {{(TICK_W-HOLD_W){1'b0}}, head_hold}) begin
                            n_pressing = 1'b0;
                            n_release  = 1'b1;
                            n_rd_idx   = ring_next(r_rd_idx);
                        end
                        o_res.pressed = 1'b1;
                    end else if (r_release) begin
                        n_release = 1'b0;
                    end else if (r_rd_idx != r_wr_idx) begin
                        n_last_x      = $signed(head[ENTRY_W-1 -: COORD_W]);
                        n_last_y      = $signed(head[HOLD_W +: COORD_W]);
                        n_pressing    = 1'b1;
                        n_press_start = i_item.now_ms;
                        o_res.pressed = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
        o_res.point_x = n_last_x;
        o_res.point_y = n_last_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_idx      <= '0;
            r_wr_idx      <= '0;
            r_pressing    <= 1'b0;
            r_release     <= 1'b0;
            r_press_start <= '0;
            r_last_x      <= '0;
            r_last_y      <= '0;
            r_wake        <= 1'b0;
            r_byp         <= 1'b0;
        end else begin
            r_rd_idx      <= n_rd_idx;
            r_wr_idx      <= n_wr_idx;
            r_pressing    <= n_pressing;
            r_release     <= n_release;
            r_press_start <= n_press_start;
            r_last_x      <= n_last_x;
            r_last_y      <= n_last_y;
            r_wake        <= n_wake;
            r_byp         <= we && (r_wr_idx == n_rd_idx);
        end
    end

    always_ff @(posedge i_clk) begin
        r_byp_data <= wdata;
    end

endmodule

`default_nettype wire
